### src/letter_block_matrix_cipher_macros.svh
// ----------------------------------------------------------------------------
// Letter block matrix cipher - assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LETTER_BLOCK_MATRIX_CIPHER_MACROS_SVH
`define LETTER_BLOCK_MATRIX_CIPHER_MACROS_SVH

`ifndef SYNTHESIS
// Consequent checked in the same cycle as the antecedent.
`define LBMC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbmc check failed");
// Consequent checked in the cycle after the antecedent.
`define LBMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbmc check failed");
`else
`define LBMC_ASSERT_SAME(lbl, ante, cons)
`define LBMC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### src/lbmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_pkg
// Shared types, constants and helper functions of the letter block cipher.
// ----------------------------------------------------------------------------
package lbmc_pkg;

    localparam int MAX_BLOCK   = 4;
    localparam int MAX_COLS    = 4;
    localparam int KEY_ROWS    = 4;
    localparam int LEN_W       = 3;
    localparam int POS_W       = 3;
    localparam int KEY_W       = 64;
    localparam int SUM_W       = 15;
    localparam int COL_W       = 2;
    localparam int VAL_W       = 5;
    localparam int PROD_W      = VAL_W + 1 + 8;
    // Power of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] LETTER_LOW  = 8'd64;
    localparam logic [7:0] LETTER_HIGH = 8'd91;
    localparam logic [7:0] LOWER_A     = 8'd97;
    localparam logic [7:0] LOWER_Z     = 8'd122;
    localparam logic [7:0] CASE_GAP    = 8'd32;

    typedef enum logic [1:0] {
        CFG_BLOCK_LEN = 2'd0,
        CFG_OUT_COLS  = 2'd1,
        CFG_KEY_UPPER = 2'd2,
        CFG_KEY_LOWER = 2'd3
    } lbmc_cfg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0] block_len;
        logic [LEN_W-1:0] out_cols;
        logic [KEY_W-1:0] key_upper;
        logic [KEY_W-1:0] key_lower;
    } lbmc_cfg_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] char_byte;
    } lbmc_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [COL_W-1:0]        column;
        logic                    last;
    } lbmc_out_t;

    // Classified item passed from the front end to the back end.
    typedef struct packed {
        logic             flush;
        logic [VAL_W-1:0] value;
    } lbmc_item_t;

    function automatic logic [LEN_W-1:0] clamp_block(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
            r = LEN_W'(1);
        else if (v > LEN_W'(MAX_BLOCK))
            r = LEN_W'(MAX_BLOCK);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_cols(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
            r = LEN_W'(1);
        else if (v > LEN_W'(MAX_COLS))
            r = LEN_W'(MAX_COLS);
        else
            r = v;
        return r;
    endfunction

    // Signed key byte at (row, col); rows past the stored four read as zero.
    function automatic logic signed [7:0] key_entry(
        input logic [KEY_W-1:0] ku,
        input logic [KEY_W-1:0] kl,
        input logic [POS_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [KEY_W-1:0] word;
        logic [2:0]       slot;
        logic [7:0]       b;
        word = row[1] ? kl : ku;
        slot = {row[0], col};
        b    = word[{slot, 3'b000} +: 8];
        if (row >= POS_W'(KEY_ROWS))
            b = '0;
        return $signed(b);
    endfunction

endpackage

### src/lbmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_front
// Input stage: takes phrase items, maps letters to 1..26 and registers the
// classified item for the queue.
// ----------------------------------------------------------------------------
module lbmc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 phrase_valid,
    output logic                 phrase_stall,
    input  lbmc_pkg::lbmc_in_t   phrase_item,
    output logic                 push_valid,
    input  logic                 push_ready,
    output lbmc_pkg::lbmc_item_t push_item
);
    import lbmc_pkg::*;

    logic       front_valid_reg;
    logic       front_valid_next;
    lbmc_item_t item_reg;
    lbmc_item_t item_next;
    logic [7:0] folded;
    logic       accept;

    assign phrase_stall = front_valid_reg && !push_ready;
    assign accept       = phrase_valid && !phrase_stall;
    assign push_valid   = front_valid_reg;
    assign push_item    = item_reg;

    always_comb
    begin
        // fold lower case onto upper case
        folded = phrase_item.char_byte;
        if (phrase_item.char_byte >= LOWER_A && phrase_item.char_byte <= LOWER_Z)
            folded = phrase_item.char_byte - CASE_GAP;
        item_next.flush = phrase_item.mode;
        item_next.value = '0;
        if (!phrase_item.mode && folded > LETTER_LOW && folded < LETTER_HIGH)
            item_next.value = VAL_W'(folded - LETTER_LOW);
    end

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (!phrase_stall)
            front_valid_next = phrase_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= front_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

### src/lbmc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_queue
// Small FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module lbmc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  lbmc_pkg::lbmc_item_t push_item,
    output logic                 head_valid,
    output lbmc_pkg::lbmc_item_t head_item,
    input  logic                 pop
);
    import lbmc_pkg::*;

    lbmc_item_t        ent_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign push       = push_valid && push_ready;
    assign head_valid = count_reg != '0;
    assign head_item  = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        if (pop)
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### src/lbmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbmc_back
// Execution stage: multiplies each value into the column accumulators,
// hands finished blocks to an emit buffer; sends a sum per unstalled cycle.
// ----------------------------------------------------------------------------
module lbmc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lbmc_pkg::lbmc_cfg_t  cfg,
    input  logic                 head_valid,
    input  lbmc_pkg::lbmc_item_t head_item,
    output logic                 pop,
    output logic                 cipher_valid,
    input  logic                 cipher_stall,
    output lbmc_pkg::lbmc_out_t  cipher_item
);
    import lbmc_pkg::*;

    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic signed [SUM_W-1:0]  acc_reg [MAX_COLS];
    logic signed [SUM_W-1:0]  acc_next [MAX_COLS];
    logic signed [SUM_W-1:0]  buf_reg [MAX_COLS];
    logic signed [SUM_W-1:0]  buf_next [MAX_COLS];
    logic signed [SUM_W-1:0]  sum_new [MAX_COLS];
    logic signed [PROD_W-1:0] prod [MAX_COLS];
    logic                     emit_busy_reg;
    logic                     emit_busy_next;
    logic [COL_W-1:0]         emit_idx_reg;
    logic [COL_W-1:0]         emit_idx_next;
    logic [LEN_W-1:0]         emit_n_reg;
    logic [LEN_W-1:0]         emit_n_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    lbmc_out_t                out_item_reg;
    lbmc_out_t                out_item_next;

    logic [LEN_W-1:0] blk_len;
    logic [LEN_W-1:0] ncols;
    logic [POS_W-1:0] pos_inc;
    logic             is_flush;
    logic             complete;
    logic             emit_last;
    logic             out_ld;
    logic             send;
    logic             loadable;

    assign blk_len   = clamp_block(cfg.block_len);
    assign ncols     = clamp_cols(cfg.out_cols);
    assign pos_inc   = pos_reg + POS_W'(1);
    assign is_flush  = head_item.flush;
    assign complete  = head_valid && (is_flush ? (pos_reg != '0)
                                               : (LEN_W'(pos_inc) >= blk_len));
    assign emit_last = (LEN_W'(emit_idx_reg) + LEN_W'(1)) == emit_n_reg;
    assign out_ld    = !out_valid_reg || !cipher_stall;
    assign send      = emit_busy_reg && out_ld;
    // buffer frees up in the cycle its last sum leaves
    assign loadable  = !emit_busy_reg || (send && emit_last);
    assign pop       = head_valid && (!complete || loadable);

    assign cipher_valid = out_valid_reg;
    assign cipher_item  = out_item_reg;

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            prod[c]    = $signed({1'b0, head_item.value})
                       * key_entry(cfg.key_upper, cfg.key_lower, pos_reg, COL_W'(c));
            sum_new[c] = acc_reg[c]
                       + {{(SUM_W-PROD_W){prod[c][PROD_W-1]}}, prod[c]};
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        buf_next       = buf_reg;
        emit_busy_next = emit_busy_reg;
        emit_idx_next  = emit_idx_reg;
        emit_n_next    = emit_n_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (send)
        begin
            out_valid_next       = 1'b1;
            out_item_next.sum    = buf_reg[emit_idx_reg];
            out_item_next.column = emit_idx_reg;
            out_item_next.last   = emit_last;
            emit_idx_next        = emit_idx_reg + COL_W'(1);
            if (emit_last)
                emit_busy_next = 1'b0;
        end
        else if (out_ld)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            if (complete)
            begin
                for (int c = 0; c < MAX_COLS; c++)
                begin
                    buf_next[c] = is_flush ? acc_reg[c] : sum_new[c];
                    acc_next[c] = '0;
                end
                pos_next       = '0;
                emit_busy_next = 1'b1;
                emit_idx_next  = '0;
                emit_n_next    = ncols;
            end
            else if (!is_flush)
            begin
                acc_next = sum_new;
                pos_next = pos_inc;
            end
            // drop a flush with no open block
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            emit_busy_reg <= 1'b0;
            emit_idx_reg  <= '0;
            emit_n_reg    <= LEN_W'(1);
            out_valid_reg <= 1'b0;
            for (int c = 0; c < MAX_COLS; c++)
                acc_reg[c] <= '0;
        end
        else
        begin
            pos_reg       <= pos_next;
            emit_busy_reg <= emit_busy_next;
            emit_idx_reg  <= emit_idx_next;
            emit_n_reg    <= emit_n_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg      <= buf_next;
        out_item_reg <= out_item_next;
    end

endmodule

### src/letter_block_matrix_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_block_matrix_cipher
// Letter block matrix cipher: block dot products of mapped letters with a key.
// ----------------------------------------------------------------------------
// Usage:
//   phrase channel (phrase_valid / phrase_stall / phrase_item) carries one
//   byte or an end-of-phrase flush per item; cipher channel (cipher_valid /
//   cipher_stall / cipher_item) carries one column sum per item, column 0
//   first, with last set on the final sum of a block.
//   Config is a plain write port (cfg_write, cfg_index, cfg_data); write only
//   while the block is idle.
//   After the item that closes a block is accepted, its first sum passes
//   the front register, queue, emit buffer and output register; further
//   sums follow one per cycle unless stalled. Throughput: one item per
//   cycle while phrase_stall is low. A block sends out_cols sums through the
//   single output register; above block_len, out_cols sets the rate.
//   A four-entry queue between the input stage and the accumulator stage lets
//   bytes keep arriving while a finished block drains from the emit buffer.
//   Reset clears accumulators, block position, queue and output; block_len
//   and out_cols return to 4 and the key to zero.
//   A stalled receiver holds the current sum; the emit buffer and the queue
//   then fill and phrase_stall rises.
// ----------------------------------------------------------------------------
`include "letter_block_matrix_cipher_macros.svh"

module letter_block_matrix_cipher (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             phrase_valid,
    output logic                             phrase_stall,
    input  lbmc_pkg::lbmc_in_t               phrase_item,
    output logic                             cipher_valid,
    input  logic                             cipher_stall,
    output lbmc_pkg::lbmc_out_t              cipher_item,
    input  logic                             cfg_write,
    input  logic [1:0]                       cfg_index,
    input  logic [lbmc_pkg::KEY_W-1:0]       cfg_data
);
    import lbmc_pkg::*;

    lbmc_cfg_t  cfg_reg;
    lbmc_cfg_t  cfg_next;
    logic       push_valid;
    logic       push_ready;
    lbmc_item_t push_item;
    logic       head_valid;
    lbmc_item_t head_item;
    logic       q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (lbmc_cfg_idx_t'(cfg_index))
                CFG_BLOCK_LEN: cfg_next.block_len = cfg_data[LEN_W-1:0];
                CFG_OUT_COLS:  cfg_next.out_cols  = cfg_data[LEN_W-1:0];
                CFG_KEY_UPPER: cfg_next.key_upper = cfg_data;
                CFG_KEY_LOWER: cfg_next.key_lower = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_len <= LEN_W'(MAX_BLOCK);
            cfg_reg.out_cols  <= LEN_W'(MAX_COLS);
            cfg_reg.key_upper <= '0;
            cfg_reg.key_lower <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lbmc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .phrase_valid (phrase_valid),
        .phrase_stall (phrase_stall),
        .phrase_item  (phrase_item),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_item    (push_item)
    );

    lbmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop)
    );

    lbmc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (q_pop),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher_item  (cipher_item)
    );

    // never pop an empty queue
    `LBMC_ASSERT_SAME(a_pop_valid, q_pop, head_valid)
    // the last sum of a block sits in the last column in use
    `LBMC_ASSERT_SAME(a_last_col, cipher_valid && cipher_item.last,
        cipher_item.column == COL_W'(clamp_cols(cfg_reg.out_cols) - LEN_W'(1)))
    // sums of one block go out back to back in column order
    `LBMC_ASSERT_NEXT(a_col_seq, cipher_valid && !cipher_item.last && !cipher_stall,
        cipher_valid && cipher_item.column == COL_W'($past(cipher_item.column) + 2'd1))

endmodule
